// ----- rtl/core/affm_pkg.sv -----
package affm_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int DATA_W = 32;
    localparam int B_W    = 34;
    localparam int P_W    = DATA_W + B_W;
    localparam int ACC_W  = P_W - FRAC_BITS + 3;
    localparam int CS_W   = FRAC_BITS + 3;
    localparam int STEP_W = 5;

    localparam logic [31:0] PI_Q30   = 32'hC90FDAA2;
    localparam logic [33:0] GAIN_Q30 = 34'h026DD3B6A;

    localparam int TURN_UNITS      = 23040;
    localparam int HALF_TURN_UNITS = 11520;
    localparam int QUARTER_UNITS   = 5760;

    typedef enum logic [3:0] {
        K_IDENT     = 4'd0,
        K_SCALE_ALL = 4'd1,
        K_SCALE_ROW = 4'd2,
        K_TRANS     = 4'd3,
        K_ROTX      = 4'd4,
        K_ROTY      = 4'd5,
        K_ROTZ      = 4'd6,
        K_XFORM     = 4'd7,
        K_LOAD      = 4'd8,
        K_MULT      = 4'd9
    } t_kind;

    typedef struct packed {
        logic                      mul;
        logic                      clr;
        logic                      sub;
        logic signed [DATA_W-1:0]  a;
        logic signed [B_W-1:0]     b;
        logic signed [DATA_W-1:0]  init;
    } t_lane_req;

    function automatic logic signed [32:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000007;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return {1'b0, v};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = -ACC_W'(64'sd2147483648);
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

// ----- rtl/core/affm_lane.sv -----
module affm_lane import affm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_lane_req                 i_req,
    output logic signed [ACC_W-1:0]   o_acc
);

    localparam logic signed [P_W-1:0] HALF = P_W'(1) <<< (FRAC_BITS - 1);

    logic signed [P_W-1:0]    r_p;
    logic                     r_mul;
    logic                     r_clr;
    logic                     r_sub;
    logic signed [DATA_W-1:0] r_init;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [P_W-1:0]    w_sum;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]  w_base;

    assign w_sum  = (r_p + HALF) >>> FRAC_BITS;
    assign w_rnd  = w_sum[ACC_W-1:0];
    assign w_base = r_clr ? ACC_W'(r_init) : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul <= 1'b0;
        end else begin
            r_mul <= i_req.mul;
        end
        r_p    <= P_W'(i_req.a) * P_W'(i_req.b);
        r_clr  <= i_req.clr;
        r_sub  <= i_req.sub;
        r_init <= i_req.init;
        if (r_mul) begin
            r_acc <= r_sub ? (w_base - w_rnd) : (w_base + w_rnd);
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- rtl/core/affm_cordic.sv -----
module affm_cordic import affm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [15:0]       i_angle,
    output logic                     o_done,
    output logic signed [CS_W-1:0]   o_cos,
    output logic signed [CS_W-1:0]   o_sin
);

    localparam int RS  = 30 - FRAC_BITS;
    localparam logic signed [B_W-1:0] RHALF = (RS == 0) ? B_W'(0) : (B_W'(1) <<< (RS - 1));

    // angle to radians: mag * PI / HALF_TURN split into quotient and remainder parts,
    // remainder part divided by HALF_TURN as a shift followed by a reciprocal multiply
    localparam int     DIV_SH = 8;
    localparam int     RCP_SH = 25;
    localparam longint PI_QUO = longint'(PI_Q30) / HALF_TURN_UNITS;
    localparam longint PI_REM = longint'(PI_Q30) % HALF_TURN_UNITS;
    localparam longint DIV_LO = HALF_TURN_UNITS >> DIV_SH;
    localparam longint RCP    = ((64'sd1 <<< RCP_SH) + DIV_LO - 1) / DIV_LO;

    typedef enum logic [2:0] {C_IDLE, C_MUL, C_DIV, C_ROT, C_OUT} t_cstate;

    t_cstate                r_state;
    logic [12:0]            r_mag;
    logic                   r_neg;
    logic                   r_zneg;
    logic [30:0]            r_zhi;
    logic [18:0]            r_lo;
    logic [STEP_W-1:0]      r_cnt;
    logic signed [B_W-1:0]  r_x;
    logic signed [B_W-1:0]  r_y;
    logic signed [32:0]     r_z;
    logic                   r_done;
    logic signed [CS_W-1:0] r_cos;
    logic signed [CS_W-1:0] r_sin;

    logic signed [17:0]     w_a0, w_a1, w_a2, w_a3, w_f;
    logic [30:0]            w_hi;
    logic [26:0]            w_lox;
    logic [39:0]            w_rp;
    logic [30:0]            w_q;
    logic signed [B_W-1:0]  w_xs, w_ys;
    logic signed [B_W-1:0]  w_xr, w_yr;

    always_comb begin
        w_a0 = 18'(i_angle);
        w_a1 = (w_a0 < 0) ? w_a0 + 18'(TURN_UNITS) : w_a0;
        w_a2 = (w_a1 < 0) ? w_a1 + 18'(TURN_UNITS) : w_a1;
        w_a3 = (w_a2 >= 18'(TURN_UNITS)) ? w_a2 - 18'(TURN_UNITS) : w_a2;
        if (w_a3 > 18'(QUARTER_UNITS) && w_a3 <= 18'(3 * QUARTER_UNITS)) begin
            w_f = w_a3 - 18'(HALF_TURN_UNITS);
        end else if (w_a3 > 18'(3 * QUARTER_UNITS)) begin
            w_f = w_a3 - 18'(TURN_UNITS);
        end else begin
            w_f = w_a3;
        end
    end

    assign w_hi   = 31'(r_mag) * 31'(PI_QUO);
    assign w_lox  = 27'(r_mag) * 27'(PI_REM) + 27'(HALF_TURN_UNITS / 2);
    assign w_rp   = 40'(r_lo) * 40'(RCP);
    assign w_q    = r_zhi + 31'(w_rp[39:RCP_SH]);
    assign w_xs   = r_x >>> r_cnt;
    assign w_ys   = r_y >>> r_cnt;
    assign w_xr   = (r_x + RHALF) >>> RS;
    assign w_yr   = (r_y + RHALF) >>> RS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_mag  <= 13'((w_f < 0) ? -w_f : w_f);
                        r_zneg <= w_f < 0;
                        r_neg  <= (w_a3 > 18'(QUARTER_UNITS)) &&
                                  (w_a3 <= 18'(3 * QUARTER_UNITS));
                        r_state <= C_MUL;
                    end
                end
                C_MUL: begin
                    r_zhi   <= w_hi;
                    r_lo    <= w_lox[26:DIV_SH];
                    r_state <= C_DIV;
                end
                C_DIV: begin
                    r_z     <= r_zneg ? -$signed({2'b00, w_q}) : $signed({2'b00, w_q});
                    r_x     <= GAIN_Q30;
                    r_y     <= '0;
                    r_cnt   <= '0;
                    r_state <= C_ROT;
                end
                C_ROT: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - atan_q30(r_cnt);
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + atan_q30(r_cnt);
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == STEP_W'(CORDIC_STEPS - 1)) begin
                        r_state <= C_OUT;
                    end
                end
                C_OUT: begin
                    r_cos   <= r_neg ? -w_xr[CS_W-1:0] : w_xr[CS_W-1:0];
                    r_sin   <= r_neg ? -w_yr[CS_W-1:0] : w_yr[CS_W-1:0];
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

// ----- rtl/core/affine_matrix_3d_engine.sv -----
// 3x4 affine matrix engine, Q16.16. A request is taken when i_start is high and
// o_busy is low. Identity, translate, load row and unknown kinds finish in the
// accepting cycle. Scale, transform and multiply run on three row lanes, each
// with one 32x34 multiplier; each matrix column is issued as one lane request
// per product term, followed by a drain state and a writeback state. A rotation
// first runs angle reduction and CORDIC, then its lane work. A transform
// result appears on o_out_* with o_valid for exactly one cycle and cannot be
// held off: the receiver must take it then.
module affine_matrix_3d_engine import affm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [3:0]          i_kind,
    input  logic [1:0]          i_row,
    input  logic signed [31:0]  i_val_a,
    input  logic signed [31:0]  i_val_b,
    input  logic signed [31:0]  i_val_c,
    input  logic signed [31:0]  i_val_d,
    input  logic signed [15:0]  i_angle,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output logic                o_valid,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_z
);

    typedef enum logic [2:0] {S_IDLE, S_CORD, S_ISSUE, S_DRAIN, S_WB} t_state;

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    t_state                  r_state;
    t_kind                   r_op;
    logic [1:0]              r_grp;
    logic [1:0]              r_term;
    logic [1:0]              r_p;
    logic [1:0]              r_q;
    logic signed [31:0]      r_m   [0:2][0:3];
    logic signed [31:0]      r_rhs [0:2][0:3];
    logic signed [31:0]      r_v   [0:2];
    logic signed [31:0]      r_d   [0:2];
    logic signed [31:0]      r_cx, r_cy, r_cz;
    logic                    r_valid;
    logic signed [31:0]      r_ox, r_oy, r_oz;

    t_lane_req               w_req [0:2];
    logic signed [ACC_W-1:0] w_acc [0:2];
    logic signed [31:0]      w_sat [0:2];
    logic                    w_acc_in;
    logic                    w_cord_go;
    logic                    w_cord_done;
    logic signed [CS_W-1:0]  w_cos, w_sin;
    logic [1:0]              w_nt;
    logic [1:0]              w_last;
    logic signed [31:0]      w_pt [0:2];
    logic signed [31:0]      w_cn [0:2];

    assign w_acc_in  = i_start && (r_state == S_IDLE);
    assign w_cord_go = w_acc_in && (i_kind == K_ROTX || i_kind == K_ROTY || i_kind == K_ROTZ);

    assign w_pt[0] = i_val_a;
    assign w_pt[1] = i_val_b;
    assign w_pt[2] = i_val_c;
    assign w_cn[0] = r_cx;
    assign w_cn[1] = r_cy;
    assign w_cn[2] = r_cz;

    affm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cord_go),
        .i_angle (i_angle),
        .o_done  (w_cord_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    for (genvar l = 0; l < 3; l++) begin : g_lane
        affm_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (w_req[l]),
            .o_acc   (w_acc[l])
        );
        assign w_sat[l] = sat32(w_acc[l]);
    end

    always_comb begin
        case (r_op)
            K_XFORM, K_MULT:     w_nt = 2'd3;
            K_ROTX, K_ROTY, K_ROTZ: w_nt = 2'd2;
            default:             w_nt = 2'd1;
        endcase
        w_last = (r_op == K_XFORM) ? 2'd0 : 2'd3;
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_req[l]      = '0;
            w_req[l].mul  = (r_state == S_ISSUE);
            w_req[l].clr  = (r_term == 2'd0);
            case (r_op)
                K_SCALE_ALL: begin
                    w_req[l].a = r_m[l][r_grp];
                    w_req[l].b = B_W'(r_v[0]);
                end
                K_SCALE_ROW: begin
                    w_req[l].a = r_m[l][r_grp];
                    w_req[l].b = B_W'(r_v[l]);
                end
                K_XFORM: begin
                    w_req[l].a    = r_d[r_term];
                    w_req[l].b    = B_W'(r_m[l][r_term]);
                    w_req[l].init = r_m[l][3];
                end
                K_MULT: begin
                    w_req[l].a    = r_m[r_term][r_grp];
                    w_req[l].b    = B_W'(r_rhs[l][r_term]);
                    w_req[l].init = (r_grp == 2'd3) ? r_rhs[l][3] : 32'sd0;
                end
                K_ROTX, K_ROTY, K_ROTZ: begin
                    w_req[l].b = (r_term == 2'd0) ? B_W'(w_cos) : B_W'(w_sin);
                    if (l == 0) begin
                        w_req[l].a = (r_term == 2'd0) ? r_m[r_p][r_grp] : r_m[r_q][r_grp];
                    end else if (l == 1) begin
                        w_req[l].a   = (r_term == 2'd0) ? r_m[r_q][r_grp] : r_m[r_p][r_grp];
                        w_req[l].sub = (r_term != 2'd0);
                    end else begin
                        w_req[l].mul = 1'b0;
                    end
                end
                default: w_req[l].mul = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                2'd0:    r_cx <= i_cfg_data;
                2'd1:    r_cy <= i_cfg_data;
                2'd2:    r_cz <= i_cfg_data;
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_cz <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in && i_kind == K_LOAD && i_row != 2'd3) begin
            r_rhs[i_row][0] <= i_val_a;
            r_rhs[i_row][1] <= i_val_b;
            r_rhs[i_row][2] <= i_val_c;
            r_rhs[i_row][3] <= i_val_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_op    <= K_IDENT;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_m[r][c] <= (r == c) ? ONE : 32'sd0;
                end
            end
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op   <= t_kind'(i_kind);
                        r_grp  <= '0;
                        r_term <= '0;
                        r_v[0] <= i_val_a;
                        r_v[1] <= i_val_b;
                        r_v[2] <= i_val_c;
                        for (int r = 0; r < 3; r++) begin
                            r_d[r] <= sat32(ACC_W'(w_pt[r]) - ACC_W'(w_cn[r]));
                        end
                        case (i_kind)
                            K_IDENT: begin
                                for (int r = 0; r < 3; r++) begin
                                    for (int c = 0; c < 4; c++) begin
                                        r_m[r][c] <= (r == c) ? ONE : 32'sd0;
                                    end
                                end
                            end
                            K_TRANS: begin
                                for (int r = 0; r < 3; r++) begin
                                    r_m[r][3] <= sat32(ACC_W'(r_m[r][3]) + ACC_W'(w_pt[r]));
                                end
                            end
                            K_SCALE_ALL, K_SCALE_ROW, K_XFORM, K_MULT: r_state <= S_ISSUE;
                            K_ROTX: begin
                                r_p     <= 2'd1;
                                r_q     <= 2'd2;
                                r_state <= S_CORD;
                            end
                            K_ROTY: begin
                                r_p     <= 2'd0;
                                r_q     <= 2'd2;
                                r_state <= S_CORD;
                            end
                            K_ROTZ: begin
                                r_p     <= 2'd1;
                                r_q     <= 2'd0;
                                r_state <= S_CORD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CORD: begin
                    if (w_cord_done) begin
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (r_term == w_nt - 2'd1) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_term <= r_term + 2'd1;
                    end
                end
                S_DRAIN: r_state <= S_WB;
                S_WB: begin
                    case (r_op)
                        K_XFORM: begin
                            r_ox    <= w_sat[0];
                            r_oy    <= w_sat[1];
                            r_oz    <= w_sat[2];
                            r_valid <= 1'b1;
                        end
                        K_ROTX, K_ROTY, K_ROTZ: begin
                            r_m[r_p][r_grp] <= w_sat[0];
                            r_m[r_q][r_grp] <= w_sat[1];
                        end
                        default: begin
                            for (int r = 0; r < 3; r++) begin
                                r_m[r][r_grp] <= w_sat[r];
                            end
                        end
                    endcase
                    r_term <= '0;
                    if (r_grp == w_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_grp   <= r_grp + 2'd1;
                        r_state <= S_ISSUE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_out_x = r_ox;
    assign o_out_y = r_oy;
    assign o_out_z = r_oz;

endmodule
